FILE: rtl/hc_pkg.sv
// Package for the Hamming codec: widths, opcodes, register indexes and
// the constant bit-placement functions used by the core.
// No dependencies.
package hc_pkg;

  localparam int unsigned CwWidth           = 63;
  localparam int unsigned DwWidth           = 57;
  localparam int unsigned SynWidth          = 6;
  localparam int unsigned PcWidth           = 3;
  localparam int unsigned CfgWidth          = 6;
  localparam int unsigned OpWidth           = 2;
  localparam int unsigned MaxCodeLenDefault = 63;

  // Stream payload layout
  localparam int unsigned InTdataWidth  = 120;  // data_word, code_word
  localparam int unsigned OutTdataWidth = 136;  // see core port list
  localparam int unsigned OutDataLsb    = CwWidth;
  localparam int unsigned OutSynLsb     = CwWidth + DwWidth;
  localparam int unsigned OutValidBit   = OutSynLsb + SynWidth;
  localparam int unsigned OutPcLsb      = OutValidBit + 1;

  typedef enum logic [OpWidth-1:0] {
    OP_ENCODE = 2'd0,
    OP_DECODE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_CODE_LEN = 1'b0,
    REG_DATA_LEN = 1'b1
  } reg_idx_e;

  function automatic logic is_pow2(int unsigned p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // Data bit k goes to the k-th position that is not a power of two
  function automatic logic [CwWidth-1:0] spread_data(logic [DwWidth-1:0] d);
    logic [CwWidth-1:0] w;
    logic [5:0]         k;
    w = '0;
    k = '0;
    for (int unsigned p = 1; p <= CwWidth; p++) begin
      if (!is_pow2(p)) begin
        w[p-1] = d[k];
        k      = k + 6'd1;
      end
    end
    return w;
  endfunction

  // Inverse of spread_data
  function automatic logic [DwWidth-1:0] gather_data(logic [CwWidth-1:0] w);
    logic [DwWidth-1:0] d;
    logic [5:0]         k;
    d = '0;
    k = '0;
    for (int unsigned p = 1; p <= CwWidth; p++) begin
      if (!is_pow2(p)) begin
        d[k] = w[p-1];
        k    = k + 6'd1;
      end
    end
    return d;
  endfunction

  // Positions that feed syndrome bit j
  function automatic logic [CwWidth-1:0] col_mask(int unsigned j);
    logic [CwWidth-1:0] m;
    for (int unsigned p = 1; p <= CwWidth; p++) begin
      m[p-1] = ((p >> j) & 1) != 0;
    end
    return m;
  endfunction

  // XOR of the positions of all set bits, one parity tree per bit
  function automatic logic [SynWidth-1:0] syndrome_of(logic [CwWidth-1:0] w);
    logic [SynWidth-1:0] s;
    for (int unsigned j = 0; j < SynWidth; j++) begin
      s[j] = ^(w & col_mask(j));
    end
    return s;
  endfunction

  // Ones in the lowest n positions
  function automatic logic [CwWidth-1:0] len_mask(logic [CfgWidth-1:0] n);
    logic [CwWidth-1:0] m;
    for (int unsigned p = 0; p < CwWidth; p++) begin
      m[p] = p < n;
    end
    return m;
  endfunction

  // Smallest r with 2^r >= n+1
  function automatic logic [PcWidth-1:0] parity_count(logic [CfgWidth-1:0] n);
    int unsigned r;
    r = 0;
    for (int unsigned i = 0; i < 7; i++) begin
      if ((1 << r) < (n + 1)) r++;
    end
    return PcWidth'(r);
  endfunction

endpackage

FILE: rtl/hamming_codec_core.sv
// Throughput: one item per cycle; three register stages (placement and
// masking, syndrome trees, correction and extraction) each take an item
// every cycle, and a stall holds each full stage in place while empty
// stages still fill.
// Reset: asynchronous, active low; clears all stage valid bits and sets
// code_length to 7 and data_length to 4.
// Depends on hc_pkg.
module hamming_codec_core #(
  parameter int unsigned MaxCodeLen = hc_pkg::MaxCodeLenDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [hc_pkg::CfgWidth-1:0]        cfg_data_i,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [hc_pkg::InTdataWidth-1:0]    s_axis_tdata,  // data_word, code_word
  input  logic [hc_pkg::OpWidth-1:0]         s_axis_tuser,  // opcode
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // code_word_out, data_out, syndrome, valid_flag, parity_count, zero pad
  output logic [hc_pkg::OutTdataWidth-1:0]   m_axis_tdata,
  output logic                               m_axis_tuser   // status
);
  import hc_pkg::*;

  // Configuration registers
  logic [CfgWidth-1:0] code_len_q, data_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_len_q <= 6'd7;
      data_len_q <= 6'd4;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CODE_LEN: code_len_q <= cfg_data_i;
        REG_DATA_LEN: data_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ready chain: a stage loads when empty or when its content moves on
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 1: effective length, parity count, data placement, masking
  logic [CfgWidth-1:0] n_eff;
  logic [PcWidth-1:0]  r_d;
  logic                mis_d;
  logic [CwWidth-1:0]  mask_d, word_d;
  op_e                 op_in;

  assign n_eff  = (code_len_q > CfgWidth'(MaxCodeLen)) ? CfgWidth'(MaxCodeLen) : code_len_q;
  assign r_d    = parity_count(n_eff);
  assign mis_d  = ({1'b0, data_len_q} + {4'd0, r_d}) != {1'b0, n_eff};
  assign mask_d = len_mask(n_eff);
  assign op_in  = op_e'(s_axis_tuser);

  always_comb begin
    case (op_in)
      OP_ENCODE:          word_d = spread_data(s_axis_tdata[DwWidth-1:0]) & mask_d;
      OP_DECODE, OP_CHECK: word_d = s_axis_tdata[DwWidth +: CwWidth] & mask_d;
      default:            word_d = '0;
    endcase
  end

  op_e                 op1_q;
  logic [CwWidth-1:0]  word1_q;
  logic [CfgWidth-1:0] n1_q;
  logic [PcWidth-1:0]  r1_q;
  logic                mis1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      op1_q   <= op_in;
      word1_q <= word_d;
      n1_q    <= n_eff;
      r1_q    <= r_d;
      mis1_q  <= mis_d;
    end
  end

  // Stage 2: syndrome trees
  op_e                 op2_q;
  logic [CwWidth-1:0]  word2_q;
  logic [CfgWidth-1:0] n2_q;
  logic [PcWidth-1:0]  r2_q;
  logic                mis2_q;
  logic [SynWidth-1:0] syn2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      op2_q   <= op1_q;
      word2_q <= word1_q;
      n2_q    <= n1_q;
      r2_q    <= r1_q;
      mis2_q  <= mis1_q;
      syn2_q  <= syndrome_of(word1_q);
    end
  end

  // Stage 3: parity insertion, correction, extraction
  logic [CwWidth-1:0]  par_bits, flip, cw_out_d;
  logic [DwWidth-1:0]  data_out_d;
  logic [SynWidth-1:0] syn_out_d;
  logic                status_d, valid_d;

  always_comb begin
    par_bits = '0;
    for (int unsigned k = 0; k < SynWidth; k++) begin
      par_bits[(1 << k) - 1] = syn2_q[k];
    end
    // Syndrome in 1..n names the bit to flip
    flip = '0;
    if (syn2_q != '0 && syn2_q <= n2_q) begin
      flip = CwWidth'(1) << (syn2_q - SynWidth'(1));
    end
    status_d   = 1'b0;
    cw_out_d   = '0;
    data_out_d = '0;
    syn_out_d  = '0;
    valid_d    = 1'b0;
    case (op2_q)
      OP_ENCODE: begin
        status_d = mis2_q;
        if (!mis2_q) cw_out_d = word2_q | par_bits;
      end
      OP_DECODE: begin
        syn_out_d  = syn2_q;
        data_out_d = gather_data(word2_q ^ flip);
      end
      OP_CHECK: begin
        syn_out_d = syn2_q;
        valid_d   = syn2_q == '0;
      end
      default: ;
    endcase
  end

  // Output register
  logic                status_q, valid_q;
  logic [CwWidth-1:0]  cw_out_q;
  logic [DwWidth-1:0]  data_out_q;
  logic [SynWidth-1:0] syn_q;
  logic [PcWidth-1:0]  r3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      status_q   <= status_d;
      cw_out_q   <= cw_out_d;
      data_out_q <= data_out_d;
      syn_q      <= syn_out_d;
      valid_q    <= valid_d;
      r3_q       <= r2_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {(OutTdataWidth - OutPcLsb - PcWidth)'(0),
                          r3_q, valid_q, syn_q, data_out_q, cw_out_q};

endmodule

FILE: rtl/hc_checker.sv
// Port-level checks on the result stream of the Hamming codec core,
// attached by a bind statement. Depends on hc_pkg and hamming_codec_core.
module hc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [hc_pkg::OutTdataWidth-1:0] m_axis_tdata,
  input logic                             m_axis_tuser
);
  import hc_pkg::*;

  // A stalled result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Length mismatch leaves every payload field but parity_count at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[OutValidBit:0] == '0)
    else $error("mismatch result carries data");

  // Valid word reports a zero syndrome and no extracted data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OutValidBit] |->
      m_axis_tdata[OutSynLsb +: SynWidth] == '0 &&
      m_axis_tdata[OutDataLsb +: DwWidth] == '0)
    else $error("valid flag with nonzero syndrome or data");

  // Parity count never exceeds six and the pad stays zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[OutPcLsb +: PcWidth] <= PcWidth'(6) &&
      m_axis_tdata[OutTdataWidth-1:OutPcLsb+PcWidth] == '0)
    else $error("parity count out of range");

endmodule

bind hamming_codec_core hc_checker u_hc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
